// ===== hw/rtl/bhs_pkg.sv =====
// Package for the bottom-up heap sorter: sizes, controller states, datapath
// operations and the command/status structs between controller and datapath.
// No dependencies.
package bhs_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic [4:0] {
    S_LOAD,
    S_SORT,
    S_BSET,
    S_SDF,
    S_SDC,
    S_SDN,
    S_BDEC,
    S_EXI,
    S_EXR,
    S_EXS,
    S_FL,
    S_FLC,
    S_SU,
    S_SUC,
    S_EXD,
    S_EMI,
    S_EMR,
    S_EMO
  } bhs_state_e;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SORT_INIT,
    OP_B_SET,
    OP_SD_FIRST,
    OP_SD_CMP,
    OP_SD_NEXT,
    OP_B_DEC,
    OP_EX_INIT,
    OP_EX_RD,
    OP_EX_SW,
    OP_FL,
    OP_FL_CMP,
    OP_SU,
    OP_SU_CMP,
    OP_EX_DEC,
    OP_EM_INIT,
    OP_EM_RD,
    OP_EM_POP
  } bhs_op_e;

  typedef struct packed {
    bhs_op_e op;
  } bhs_cmd_t;

  typedef struct packed {
    logic lin;       // left child of node inside heap
    logic big_is_n;  // sift-down: held value not below either child
    logic su_gt;     // sift-up: held value beats parent
    logic root;      // node index is zero
    logic k_one;     // loop index is one
    logic em_last;   // emit index on final element
    logic cnt_lt2;
    logic cnt_zero;
  } bhs_stat_t;

endpackage

// ===== hw/rtl/bhs_dp.sv =====
// Datapath of the heap sorter: element store, read registers, node and loop
// indices, held value, element count and overflow flag. Uses bhs_pkg.
module bhs_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bhs_pkg::bhs_cmd_t                  cmd_i,
  output bhs_pkg::bhs_stat_t                 stat_o,
  input  logic [bhs_pkg::DATA_W-1:0]         value_i,
  output logic [bhs_pkg::DATA_W-1:0]         sorted_value_o,
  output logic                               last_out_o,
  output logic                               dropped_o
);
  import bhs_pkg::*;

  logic [DATA_W-1:0] mem_q [MAX_ITEMS];
  logic [DATA_W-1:0] ra_q, rb_q, hold_q, hold_d;
  logic [IDX_W-1:0]  n_q, n_d, k_q, k_d, he_q, he_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;

  logic              we, re_a, re_b;
  logic [IDX_W-1:0]  waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata;

  logic [IDX_W:0]    l_c;
  logic [IDX_W+1:0]  r_c;
  logic [IDX_W-1:0]  l_idx, r_idx, p_idx;
  logic              lin, rin, l_gt, r_gt, pick_r, su_gt, em_last;
  logic [DATA_W-1:0] big_val;

  assign l_c   = {n_q, 1'b1};
  assign r_c   = {1'b0, l_c} + (IDX_W + 2)'(1);
  assign l_idx = l_c[IDX_W-1:0];
  assign r_idx = r_c[IDX_W-1:0];
  assign p_idx = (n_q - IDX_W'(1)) >> 1;
  assign lin   = l_c <= {1'b0, he_q};
  assign rin   = r_c <= {2'b00, he_q};

  assign l_gt    = $signed(ra_q) > $signed(hold_q);
  assign big_val = l_gt ? ra_q : hold_q;
  assign r_gt    = rin && ($signed(rb_q) > $signed(big_val));
  assign pick_r  = rin && !($signed(ra_q) > $signed(rb_q));
  assign su_gt   = $signed(hold_q) > $signed(ra_q);
  assign em_last = (CNT_W'(k_q) + CNT_W'(1)) == cnt_q;

  always_comb begin
    stat_o.lin      = lin;
    stat_o.big_is_n = !l_gt && !r_gt;
    stat_o.su_gt    = su_gt;
    stat_o.root     = n_q == '0;
    stat_o.k_one    = k_q == IDX_W'(1);
    stat_o.em_last  = em_last;
    stat_o.cnt_lt2  = cnt_q < CNT_W'(2);
    stat_o.cnt_zero = cnt_q == '0;
  end

  always_comb begin
    we      = 1'b0;
    re_a    = 1'b0;
    re_b    = 1'b0;
    waddr   = n_q;
    wdata   = hold_q;
    raddr_a = l_idx;
    raddr_b = r_idx;
    n_d     = n_q;
    k_d     = k_q;
    he_d    = he_q;
    hold_d  = hold_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    case (cmd_i.op)
      OP_LOAD: begin
        if (cnt_q < CNT_W'(MAX_ITEMS)) begin
          we    = 1'b1;
          waddr = cnt_q[IDX_W-1:0];
          wdata = value_i;
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      OP_SORT_INIT: begin
        he_d = IDX_W'(cnt_q - CNT_W'(1));
        k_d  = IDX_W'(cnt_q >> 1);
      end
      OP_B_SET: begin
        n_d     = k_q - IDX_W'(1);
        re_a    = 1'b1;
        raddr_a = k_q - IDX_W'(1);
      end
      OP_SD_FIRST: begin
        hold_d = ra_q;
        re_a   = lin;
        re_b   = lin;
      end
      OP_SD_CMP: begin
        we = 1'b1;
        if (!l_gt && !r_gt) begin
          wdata = hold_q;
        end else begin
          wdata = r_gt ? rb_q : ra_q;
          n_d   = r_gt ? r_idx : l_idx;
        end
      end
      OP_SD_NEXT: begin
        re_a = lin;
        re_b = lin;
        we   = !lin;
      end
      OP_B_DEC, OP_EX_DEC: begin
        k_d = k_q - IDX_W'(1);
      end
      OP_EX_INIT: begin
        k_d = IDX_W'(cnt_q - CNT_W'(1));
      end
      OP_EX_RD: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = '0;
        raddr_b = k_q;
      end
      OP_EX_SW: begin
        hold_d = rb_q;
        we     = 1'b1;
        waddr  = k_q;
        wdata  = ra_q;
        he_d   = k_q - IDX_W'(1);
        n_d    = '0;
      end
      OP_FL: begin
        re_a = lin;
        re_b = lin;
      end
      OP_FL_CMP: begin
        we    = 1'b1;
        wdata = pick_r ? rb_q : ra_q;
        n_d   = pick_r ? r_idx : l_idx;
      end
      OP_SU: begin
        if (n_q == '0) begin
          we = 1'b1;
        end else begin
          re_a    = 1'b1;
          raddr_a = p_idx;
        end
      end
      OP_SU_CMP: begin
        we = 1'b1;
        if (su_gt) begin
          wdata = ra_q;
          n_d   = p_idx;
        end
      end
      OP_EM_INIT: begin
        k_d = '0;
      end
      OP_EM_RD: begin
        re_a    = 1'b1;
        raddr_a = k_q;
      end
      OP_EM_POP: begin
        if (em_last) begin
          cnt_d = '0;
          ovf_d = 1'b0;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re_a) begin
      ra_q <= mem_q[raddr_a];
    end
    if (re_b) begin
      rb_q <= mem_q[raddr_b];
    end
    hold_q <= hold_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      k_q   <= '0;
      he_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      n_q   <= n_d;
      k_q   <= k_d;
      he_q  <= he_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign sorted_value_o = ra_q;
  assign last_out_o     = em_last;
  assign dropped_o      = ovf_q;

endmodule

// ===== hw/rtl/bhs_ctrl.sv =====
// Controller of the heap sorter: load, heap build, extraction and emit
// sequencing. Uses bhs_pkg; drives the datapath in bhs_dp.
module bhs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output bhs_pkg::bhs_cmd_t   cmd_o,
  input  bhs_pkg::bhs_stat_t  stat_i
);
  import bhs_pkg::*;

  bhs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_IDLE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (in_last_i) begin
            state_d = S_SORT;
          end
        end
      end
      S_SORT: begin
        cmd_o.op = OP_SORT_INIT;
        if (stat_i.cnt_zero) begin
          state_d = S_LOAD;
        end else if (stat_i.cnt_lt2) begin
          state_d = S_EMI;
        end else begin
          state_d = S_BSET;
        end
      end
      S_BSET: begin
        cmd_o.op = OP_B_SET;
        state_d  = S_SDF;
      end
      S_SDF: begin
        cmd_o.op = OP_SD_FIRST;
        state_d  = stat_i.lin ? S_SDC : S_BDEC;
      end
      S_SDC: begin
        cmd_o.op = OP_SD_CMP;
        state_d  = stat_i.big_is_n ? S_BDEC : S_SDN;
      end
      S_SDN: begin
        cmd_o.op = OP_SD_NEXT;
        state_d  = stat_i.lin ? S_SDC : S_BDEC;
      end
      S_BDEC: begin
        if (stat_i.k_one) begin
          state_d = S_EXI;
        end else begin
          cmd_o.op = OP_B_DEC;
          state_d  = S_BSET;
        end
      end
      S_EXI: begin
        cmd_o.op = OP_EX_INIT;
        state_d  = S_EXR;
      end
      S_EXR: begin
        cmd_o.op = OP_EX_RD;
        state_d  = S_EXS;
      end
      S_EXS: begin
        cmd_o.op = OP_EX_SW;
        state_d  = S_FL;
      end
      S_FL: begin
        cmd_o.op = OP_FL;
        state_d  = stat_i.lin ? S_FLC : S_SU;
      end
      S_FLC: begin
        cmd_o.op = OP_FL_CMP;
        state_d  = S_FL;
      end
      S_SU: begin
        cmd_o.op = OP_SU;
        state_d  = stat_i.root ? S_EXD : S_SUC;
      end
      S_SUC: begin
        cmd_o.op = OP_SU_CMP;
        state_d  = stat_i.su_gt ? S_SU : S_EXD;
      end
      S_EXD: begin
        if (stat_i.k_one) begin
          state_d = S_EMI;
        end else begin
          cmd_o.op = OP_EX_DEC;
          state_d  = S_EXR;
        end
      end
      S_EMI: begin
        cmd_o.op = OP_EM_INIT;
        state_d  = S_EMR;
      end
      S_EMR: begin
        cmd_o.op = OP_EM_RD;
        state_d  = S_EMO;
      end
      S_EMO: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.op = OP_EM_POP;
          state_d  = stat_i.em_last ? S_LOAD : S_EMR;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bottom_up_heap_sorter_core.sv =====
// Top level of the bottom-up heap sorter: stream ports, controller and datapath.
// Depends on bhs_pkg, bhs_ctrl and bhs_dp.
//
//   channel  dir  handshake                      payload
//   s_axis   in   s_axis_tvalid_i/s_axis_tready_o  tdata=value, tlast=last
//   m_axis   out  m_axis_tvalid_o/m_axis_tready_i  tdata=sorted_value, tlast=last_out,
//                                                  tuser=dropped
//
// Load: one beat a cycle while idle; the beat marked last starts the sort.
// Build: for each parent a set and a first read, then a compare and a next read per
// level moved; extraction reads root and last, swaps, floats down, sifts up and
// steps on, each step waiting on the registered reads of the element store. Emit: a read and an output state per beat.
// Reset returns to load with an empty set; a stalled output beat holds.
module bottom_up_heap_sorter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [bhs_pkg::DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic                       s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [bhs_pkg::DATA_W-1:0] m_axis_tdata_o,  // [31:0] sorted_value
  output logic                       m_axis_tlast_o,
  output logic                       m_axis_tuser_o   // [0] dropped
);
  import bhs_pkg::*;

  bhs_cmd_t  cmd;
  bhs_stat_t stat;
  logic      in_beat;

  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  bhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  bhs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_i        (s_axis_tdata_i),
    .sorted_value_o (m_axis_tdata_o),
    .last_out_o     (m_axis_tlast_o),
    .dropped_o      (m_axis_tuser_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid_o && s_axis_tready_o))
    else $error("output beat offered while loading");

  a_last_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input still open after final beat");

  a_emit_ends_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=>
      (s_axis_tready_o && !m_axis_tvalid_o))
    else $error("set not closed after final output beat");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bottom_up_heap_sorter_core: streams sets of signed
// values in, predicts the ascending output beats and compares every field.
// Depends on bhs_pkg and the sorter RTL.
module tb_top;
  import bhs_pkg::*;

  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_BEATS  = 205;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              last;
  } in_beat_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     dropped;
  } sorted_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic              m_axis_tuser;

  in_beat_t     stimulus_q[$];
  sorted_beat_t sorted_due[$];

  logic signed [DATA_W-1:0] held_set [MAX_ITEMS];
  int   held_count = 0;
  logic held_overflow = 1'b0;

  logic in_beat_taken = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;

  bottom_up_heap_sorter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Hold the beat; on the last mark sort the held set and queue it ascending.
  task automatic predict_sorted(input logic signed [DATA_W-1:0] value, input logic last);
    logic signed [DATA_W-1:0] key;
    int j;
    if (held_count < MAX_ITEMS) begin
      held_set[held_count] = value;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (last) begin
      for (int i = 1; i < held_count; i++) begin
        key = held_set[i];
        j = i - 1;
        while (j >= 0 && held_set[j] > key) begin
          held_set[j + 1] = held_set[j];
          j--;
        end
        held_set[j + 1] = key;
      end
      for (int k = 0; k < held_count; k++) begin
        sorted_due.push_back('{held_set[k], (k + 1 == held_count) ? 1'b1 : 1'b0,
                               held_overflow});
      end
      held_count = 0;
      held_overflow = 1'b0;
    end
  endtask

  task automatic check_sorted_beat();
    sorted_beat_t due;
    if (sorted_due.size() == 0) begin
      report_mismatch($sformatf("unexpected beat %0d", $signed(m_axis_tdata)));
    end else begin
      due = sorted_due.pop_front();
      if (m_axis_tdata !== due.value)
        report_mismatch($sformatf("value %0d, want %0d", $signed(m_axis_tdata), due.value));
      if (m_axis_tlast !== due.last)
        report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, due.last));
      if (m_axis_tuser !== due.dropped)
        report_mismatch($sformatf("dropped %b, want %b", m_axis_tuser, due.dropped));
    end
  endtask

  function automatic bit idling_on();
    return stimulus_q.size() > 40 && (stimulus_q.size() / 30) % 3 != 1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3:       return DATA_W'($signed($urandom_range(0, 8)) - 4);
      4:       return {1'b1, {(DATA_W - 1){1'b0}}};
      default: return {1'b0, {(DATA_W - 1){1'b1}}};
    endcase
  endfunction

  task automatic push_beat(input logic [DATA_W-1:0] value, input logic last);
    stimulus_q.push_back('{value, last});
  endtask

  task automatic push_set(input int count);
    for (int i = 0; i < count; i++) push_beat(pick_value(), i == count - 1);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_sorted(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_sorted_beat();
    end
    in_beat_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_beat_taken) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 14);
        s_axis_tvalid <= 1'b0;
      end else if (stimulus_q.size() != 0) begin
        s_axis_tdata <= stimulus_q[0].value;
        s_axis_tlast <= stimulus_q[0].last;
        s_axis_tvalid <= 1'b1;
        stimulus_q.delete(0);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on() && $urandom_range(0, 5) == 0) begin
      out_gap <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bottom_up_heap_sorter_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int random_beats;
    int set_no;
    int count;
    random_beats = 0;
    set_no = 0;

    // single-element sets at both extremes
    push_beat(32'h8000_0000, 1'b1);
    push_beat(32'h7fff_ffff, 1'b1);
    push_beat(32'h7fff_ffff, 1'b0);
    push_beat(32'h8000_0000, 1'b1);
    // equal pair
    push_beat(32'hffff_ffff, 1'b0);
    push_beat(32'hffff_ffff, 1'b1);
    push_beat(32'h0000_0000, 1'b0);
    push_beat(32'hffff_ffff, 1'b0);
    push_beat(32'h0000_0001, 1'b0);
    push_beat(32'h8000_0000, 1'b0);
    push_beat(32'h7fff_ffff, 1'b1);
    // strictly descending, then a mixed set with repeats
    for (int i = 0; i < 8; i++) push_beat(DATA_W'(7 - 2 * i), i == 7);
    push_beat(32'h0000_0003, 1'b0);
    push_beat(32'h0000_0003, 1'b0);
    push_beat(32'h5555_5555, 1'b0);
    push_beat(32'haaaa_aaaa, 1'b0);
    push_beat(32'h0000_0003, 1'b0);
    push_beat(32'haaaa_aaaa, 1'b1);

    // mostly short sets; one full store and one set that overruns it
    while (random_beats < RANDOM_BEATS) begin
      if (set_no == 2) count = MAX_ITEMS;
      else if (set_no == 5) count = MAX_ITEMS + $urandom_range(1, 6);
      else count = $urandom_range(1, 12);
      push_set(count);
      random_beats += count;
      set_no++;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stimulus_q.size() != 0 || s_axis_tvalid || sorted_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("bottom_up_heap_sorter_core: match");
    end else begin
      $display("bottom_up_heap_sorter_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bhs_pkg.sv
hw/rtl/bhs_dp.sv
hw/rtl/bhs_ctrl.sv
hw/rtl/bottom_up_heap_sorter_core.sv
verif/tb_top.sv
